FILE: rtl/h264ls_pkg.sv
`timescale 1ns / 1ps

package h264ls_pkg;

    // field and datapath widths
    localparam int DimW    = 15;
    localparam int RefW    = 5;
    localparam int RateW   = 31;
    localparam int CodeW   = 6;
    localparam int RowW    = 5;
    localparam int MbSideW = 12;
    localparam int MbfW    = 23;
    localparam int DpbW    = MbfW + RefW;
    localparam int QuoW    = 54;
    localparam int RemW    = RateW + 1;
    localparam int CntW    = 6;

    // division runs one quotient bit per cycle
    localparam int DivSteps = QuoW;
    localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

    // limit table rows
    localparam int LevelRows = 17;
    localparam logic [RowW-1:0] RowLast = RowW'(LevelRows - 1);

    typedef struct packed {
        logic [DimW-1:0]  frame_width;
        logic [DimW-1:0]  frame_height;
        logic [RefW-1:0]  ref_count;
        logic             is_interlaced;
        logic [RateW-1:0] rate_numerator;
        logic [RateW-1:0] rate_denominator;
        logic [RateW-1:0] peak_bitrate;
        logic [RateW-1:0] buffer_size;
    } query_t;

    typedef struct packed {
        logic [CodeW-1:0] level_code;
        logic [RowW-1:0]  level_row;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_MULT,
        ST_ADD,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic            load;
        logic            frame;
        logic            mult;
        logic            add;
        logic            div_step;
        logic            walk_step;
        logic [RowW-1:0] row;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic fit;
    } dp_status_t;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             allow_il;
        logic [21:0]      max_mb_sec;
        logic [15:0]      max_frame_mbs;
        logic [17:0]      max_dpb;
        logic [17:0]      max_vbv_rate;
        logic [17:0]      max_vbv_buf;
    } level_limit_t;

    function automatic level_limit_t level_limit(input logic [RowW-1:0] row);
        level_limit_t l;
        l = '{code: '0, allow_il: 1'b0, max_mb_sec: '0, max_frame_mbs: '0,
              max_dpb: '0, max_vbv_rate: '0, max_vbv_buf: '0};
        unique case (row)
            5'd0:  l = '{6'd10, 1'b0, 22'd1485,    16'd99,    18'd396,    18'd64,     18'd175};
            5'd1:  l = '{6'd9,  1'b0, 22'd1485,    16'd99,    18'd396,    18'd128,    18'd350};
            5'd2:  l = '{6'd11, 1'b0, 22'd3000,    16'd396,   18'd900,    18'd192,    18'd500};
            5'd3:  l = '{6'd12, 1'b0, 22'd6000,    16'd396,   18'd2376,   18'd384,    18'd1000};
            5'd4:  l = '{6'd13, 1'b0, 22'd11880,   16'd396,   18'd2376,   18'd768,    18'd2000};
            5'd5:  l = '{6'd20, 1'b0, 22'd11880,   16'd396,   18'd2376,   18'd2000,   18'd2000};
            5'd6:  l = '{6'd21, 1'b1, 22'd19800,   16'd792,   18'd4752,   18'd4000,   18'd4000};
            5'd7:  l = '{6'd22, 1'b1, 22'd20250,   16'd1620,  18'd8100,   18'd4000,   18'd4000};
            5'd8:  l = '{6'd30, 1'b1, 22'd40500,   16'd1620,  18'd8100,   18'd10000,  18'd10000};
            5'd9:  l = '{6'd31, 1'b1, 22'd108000,  16'd3600,  18'd18000,  18'd14000,  18'd14000};
            5'd10: l = '{6'd32, 1'b1, 22'd216000,  16'd5120,  18'd20480,  18'd20000,  18'd20000};
            5'd11: l = '{6'd40, 1'b1, 22'd245760,  16'd8192,  18'd32768,  18'd20000,  18'd25000};
            5'd12: l = '{6'd41, 1'b1, 22'd245760,  16'd8192,  18'd32768,  18'd50000,  18'd62500};
            5'd13: l = '{6'd42, 1'b1, 22'd522240,  16'd8704,  18'd34816,  18'd50000,  18'd62500};
            5'd14: l = '{6'd50, 1'b0, 22'd589824,  16'd22080, 18'd110400, 18'd135000, 18'd135000};
            5'd15: l = '{6'd51, 1'b0, 22'd983040,  16'd36864, 18'd184320, 18'd240000, 18'd240000};
            5'd16: l = '{6'd52, 1'b0, 22'd2073600, 16'd36864, 18'd184320, 18'd240000, 18'd240000};
            default: l = '{code: '0, allow_il: 1'b0, max_mb_sec: '0, max_frame_mbs: '0,
                           max_dpb: '0, max_vbv_rate: '0, max_vbv_buf: '0};
        endcase
        return l;
    endfunction

endpackage

FILE: rtl/h264ls_ctrl.sv
`timescale 1ns / 1ps

module h264ls_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  h264ls_pkg::dp_status_t  status,
    output h264ls_pkg::ctrl_cmd_t   cmd,
    output logic                    busy,
    output logic                    done
);

    h264ls_pkg::state_t             state_reg, state_next;
    logic [h264ls_pkg::CntW-1:0]    cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= h264ls_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            h264ls_pkg::ST_IDLE:
                if (start)
                    state_next = h264ls_pkg::ST_FRAME;
            h264ls_pkg::ST_FRAME: state_next = h264ls_pkg::ST_MULT;
            h264ls_pkg::ST_MULT:  state_next = h264ls_pkg::ST_ADD;
            h264ls_pkg::ST_ADD:   state_next = h264ls_pkg::ST_DIV;
            h264ls_pkg::ST_DIV:
                if (cnt_reg == h264ls_pkg::DivLast)
                    state_next = h264ls_pkg::ST_WALK;
            h264ls_pkg::ST_WALK:
                if (status.fit || cnt_reg[h264ls_pkg::RowW-1:0] == h264ls_pkg::RowLast)
                    state_next = h264ls_pkg::ST_DONE;
            h264ls_pkg::ST_DONE:  state_next = h264ls_pkg::ST_IDLE;
            default:              state_next = h264ls_pkg::ST_IDLE;
        endcase
    end

    // step counter: quotient bits, then table rows
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (state_reg)
            h264ls_pkg::ST_ADD:  cnt_next = '0;
            h264ls_pkg::ST_DIV:
                cnt_next = (cnt_reg == h264ls_pkg::DivLast) ? '0 : cnt_reg + 1'b1;
            h264ls_pkg::ST_WALK: cnt_next = cnt_reg + 1'b1;
            default:             cnt_next = cnt_reg;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.load      = (state_reg == h264ls_pkg::ST_IDLE) && start;
        cmd.frame     = (state_reg == h264ls_pkg::ST_FRAME);
        cmd.mult      = (state_reg == h264ls_pkg::ST_MULT);
        cmd.add       = (state_reg == h264ls_pkg::ST_ADD);
        cmd.div_step  = (state_reg == h264ls_pkg::ST_DIV);
        cmd.walk_step = (state_reg == h264ls_pkg::ST_WALK);
        cmd.row       = cnt_reg[h264ls_pkg::RowW-1:0];
        busy          = (state_reg != h264ls_pkg::ST_IDLE);
        done          = (state_reg == h264ls_pkg::ST_DONE);
    end

endmodule

FILE: rtl/h264ls_dpath.sv
`timescale 1ns / 1ps

module h264ls_dpath (
    input  logic                    clk,
    input  h264ls_pkg::query_t      query,
    input  h264ls_pkg::ctrl_cmd_t   cmd,
    output h264ls_pkg::dp_status_t  status,
    output h264ls_pkg::result_t     result
);

    h264ls_pkg::query_t                 q_reg;
    logic [h264ls_pkg::MbfW-1:0]        mbf_reg;
    logic [h264ls_pkg::DpbW-1:0]        dpb_reg;
    logic [h264ls_pkg::QuoW-1:0]        prod_reg;
    logic [h264ls_pkg::QuoW-1:0]        nq_reg;
    logic [h264ls_pkg::RemW-1:0]        rem_reg;
    logic [h264ls_pkg::CodeW-1:0]       code_reg;
    logic [h264ls_pkg::RowW-1:0]        row_reg;

    logic [h264ls_pkg::DimW:0]          w_up, h_up16, h_up32;
    logic [h264ls_pkg::MbSideW-1:0]     mb_w, mb_h;
    logic [h264ls_pkg::RemW-1:0]        rem_sh, den_ext;
    logic                               q_bit;
    h264ls_pkg::level_limit_t           lim;
    logic                               fit;

    // macroblock counts, height to 32 lines when interlaced
    always_comb
    begin
        w_up   = {1'b0, q_reg.frame_width} + (h264ls_pkg::DimW+1)'(15);
        h_up16 = {1'b0, q_reg.frame_height} + (h264ls_pkg::DimW+1)'(15);
        h_up32 = {1'b0, q_reg.frame_height} + (h264ls_pkg::DimW+1)'(31);
        mb_w   = w_up[h264ls_pkg::DimW:4];
        if (q_reg.is_interlaced)
            mb_h = {h_up32[h264ls_pkg::DimW:5], 1'b0};
        else
            mb_h = h_up16[h264ls_pkg::DimW:4];
    end

    // one restoring division step
    always_comb
    begin
        rem_sh  = {rem_reg[h264ls_pkg::RemW-2:0], nq_reg[h264ls_pkg::QuoW-1]};
        den_ext = {1'b0, q_reg.rate_denominator};
        q_bit   = (rem_sh >= den_ext);
    end

    // limit check against the current row
    always_comb
    begin
        lim = h264ls_pkg::level_limit(cmd.row);
        fit = !(q_reg.is_interlaced && !lim.allow_il)
              && (nq_reg <= h264ls_pkg::QuoW'(lim.max_mb_sec))
              && (mbf_reg <= h264ls_pkg::MbfW'(lim.max_frame_mbs))
              && (dpb_reg <= h264ls_pkg::DpbW'(lim.max_dpb))
              && (q_reg.peak_bitrate <= h264ls_pkg::RateW'(lim.max_vbv_rate))
              && (q_reg.buffer_size <= h264ls_pkg::RateW'(lim.max_vbv_buf));
        status.fit = fit;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg    <= query;
            code_reg <= '0;
            row_reg  <= '0;
        end
        if (cmd.frame)
            mbf_reg <= h264ls_pkg::MbfW'(mb_w * mb_h);
        if (cmd.mult)
        begin
            prod_reg <= h264ls_pkg::QuoW'(mbf_reg * q_reg.rate_numerator);
            dpb_reg  <= h264ls_pkg::DpbW'(mbf_reg * q_reg.ref_count);
        end
        if (cmd.add)
        begin
            // numerator plus divisor minus one rounds the quotient up
            nq_reg  <= prod_reg + h264ls_pkg::QuoW'(q_reg.rate_denominator)
                       - h264ls_pkg::QuoW'(1);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            nq_reg  <= {nq_reg[h264ls_pkg::QuoW-2:0], q_bit};
            rem_reg <= q_bit ? (rem_sh - den_ext) : rem_sh;
        end
        if (cmd.walk_step && fit)
        begin
            code_reg <= lim.code;
            row_reg  <= cmd.row + 1'b1;
        end
    end

    assign result.level_code = code_reg;
    assign result.level_row  = row_reg;

endmodule

FILE: rtl/h264_level_selector.sv
`timescale 1ns / 1ps
// the time from the start beat to the done strobe is set by the 54-step bit-serial
// divider for macroblocks per second and the walk over up to 17 limit rows
// one query at a time: the next start beat is taken only once the controller is back
// in idle; busy stays high until the done strobe cycle ends
// result is valid on the result port from the done cycle until the next start beat is taken; the receiver cannot stall
// reset (rst_n, asynchronous, active low) returns the controller to idle, no result pending
module h264_level_selector (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  h264ls_pkg::query_t    query,
    output logic                  busy,
    output logic                  done,
    output h264ls_pkg::result_t   result
);

    h264ls_pkg::ctrl_cmd_t   cmd;
    h264ls_pkg::dp_status_t  status;

    // sequencer
    h264ls_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // arithmetic and limit check
    h264ls_dpath u_dpath (
        .clk    (clk),
        .query  (query),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    // limits of one table row, all figures widened to 32 bits
    typedef struct packed {
        logic [31:0] code;
        logic        allow_il;
        logic [31:0] mb_sec;
        logic [31:0] frame_lim;
        logic [31:0] dpb;
        logic [31:0] vbv_rate;
        logic [31:0] vbv_buf;
    } level_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    h264ls_pkg::query_t   query;
    logic                 busy;
    logic                 done;
    h264ls_pkg::result_t  result;

    h264ls_pkg::result_t  expected_levels[$];
    h264ls_pkg::result_t  oldest_level;
    int                   fail_count;

    h264_level_selector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .query  (query),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // level limit table, level 1 up to 5.2
    function automatic level_row_t limit_of(input int r);
        level_row_t l;
        l = '0;
        case (r)
            0:  l = '{10, 1'b0, 1485,    99,    396,    64,     175};
            1:  l = '{9,  1'b0, 1485,    99,    396,    128,    350};
            2:  l = '{11, 1'b0, 3000,    396,   900,    192,    500};
            3:  l = '{12, 1'b0, 6000,    396,   2376,   384,    1000};
            4:  l = '{13, 1'b0, 11880,   396,   2376,   768,    2000};
            5:  l = '{20, 1'b0, 11880,   396,   2376,   2000,   2000};
            6:  l = '{21, 1'b1, 19800,   792,   4752,   4000,   4000};
            7:  l = '{22, 1'b1, 20250,   1620,  8100,   4000,   4000};
            8:  l = '{30, 1'b1, 40500,   1620,  8100,   10000,  10000};
            9:  l = '{31, 1'b1, 108000,  3600,  18000,  14000,  14000};
            10: l = '{32, 1'b1, 216000,  5120,  20480,  20000,  20000};
            11: l = '{40, 1'b1, 245760,  8192,  32768,  20000,  25000};
            12: l = '{41, 1'b1, 245760,  8192,  32768,  50000,  62500};
            13: l = '{42, 1'b1, 522240,  8704,  34816,  50000,  62500};
            14: l = '{50, 1'b0, 589824,  22080, 110400, 135000, 135000};
            15: l = '{51, 1'b0, 983040,  36864, 184320, 240000, 240000};
            16: l = '{52, 1'b0, 2073600, 36864, 184320, 240000, 240000};
            default: l = '0;
        endcase
        return l;
    endfunction

    // macroblocks per frame, interlaced height rounded to 32 lines
    function automatic logic [63:0] frame_mbs(input logic [h264ls_pkg::DimW-1:0] w,
                                              input logic [h264ls_pkg::DimW-1:0] h,
                                              input logic il);
        logic [63:0] mb_w;
        logic [63:0] mb_h;
        mb_w = (64'(w) + 64'd15) / 64'd16;
        if (il)
            mb_h = 64'd2 * ((64'(h) + 64'd31) / 64'd32);
        else
            mb_h = (64'(h) + 64'd15) / 64'd16;
        return mb_w * mb_h;
    endfunction

    // lowest level admitting the query
    function automatic h264ls_pkg::result_t predict_level(input h264ls_pkg::query_t q);
        logic [63:0]          mbf;
        logic [63:0]          sec;
        logic [63:0]          dpb;
        logic [63:0]          num;
        logic [63:0]          den;
        level_row_t           lim;
        h264ls_pkg::result_t  r;
        bit                   found;
        int                   i;
        mbf = frame_mbs(q.frame_width, q.frame_height, q.is_interlaced);
        num = 64'(q.rate_numerator);
        den = 64'(q.rate_denominator);
        // a zero denominator reads as an all-ones rate
        if (den == 64'd0)
            sec = '1;
        else
            sec = (mbf * num + den - 64'd1) / den;
        dpb = mbf * 64'(q.ref_count);
        r = '0;
        found = 1'b0;
        for (i = 0; i < h264ls_pkg::LevelRows; i++)
        begin
            lim = limit_of(i);
            if (!found && !(q.is_interlaced && !lim.allow_il) &&
                sec <= 64'(lim.mb_sec) && mbf <= 64'(lim.frame_lim) &&
                dpb <= 64'(lim.dpb) && 64'(q.peak_bitrate) <= 64'(lim.vbv_rate) &&
                64'(q.buffer_size) <= 64'(lim.vbv_buf))
            begin
                r.level_code = lim.code[h264ls_pkg::CodeW-1:0];
                r.level_row  = h264ls_pkg::RowW'(i + 1);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic h264ls_pkg::query_t make_query(input int w, input int h,
                                                      input int refs,
                                                      input bit il, input longint num,
                                                      input longint den, input longint vbr,
                                                      input longint vbb);
        h264ls_pkg::query_t q;
        q.frame_width      = h264ls_pkg::DimW'(w);
        q.frame_height     = h264ls_pkg::DimW'(h);
        q.ref_count        = h264ls_pkg::RefW'(refs);
        q.is_interlaced    = il;
        q.rate_numerator   = h264ls_pkg::RateW'(num);
        q.rate_denominator = h264ls_pkg::RateW'(den);
        q.peak_bitrate     = h264ls_pkg::RateW'(vbr);
        q.buffer_size      = h264ls_pkg::RateW'(vbb);
        return q;
    endfunction

    // clamp a 64-bit figure into a rate field
    function automatic logic [h264ls_pkg::RateW-1:0] clamp_rate(input logic [63:0] v);
        if (v > 64'h7FFF_FFFF)
            return '1;
        return v[h264ls_pkg::RateW-1:0];
    endfunction

    // encoder-like query aimed at the limits of one random row
    function automatic h264ls_pkg::query_t plausible_query();
        h264ls_pkg::query_t q;
        level_row_t         lim;
        int unsigned        mbw;
        int unsigned        mbh;
        int unsigned        cap;
        int unsigned        w;
        int unsigned        h;
        logic [63:0]        mbf;
        logic [63:0]        den;
        logic [63:0]        num;
        lim = limit_of($urandom_range(0, h264ls_pkg::LevelRows - 1));
        q.is_interlaced = ($urandom_range(0, 3) == 0);
        cap = (lim.frame_lim > 2046) ? 2046 : lim.frame_lim;
        mbw = $urandom_range(1, cap);
        cap = lim.frame_lim / mbw + 1;
        if (cap > 2046)
            cap = 2046;
        mbh = $urandom_range(1, cap);
        if (q.is_interlaced)
            mbh = mbh + (mbh % 2);
        w = mbw * 16 - $urandom_range(0, 15);
        h = mbh * 16 - $urandom_range(0, q.is_interlaced ? 31 : 15);
        if (h < 1)
            h = 1;
        q.frame_width  = h264ls_pkg::DimW'(w);
        q.frame_height = h264ls_pkg::DimW'(h);
        mbf = frame_mbs(q.frame_width, q.frame_height, q.is_interlaced);
        // rate placed on the macroblock rate boundary of the row
        case ($urandom_range(0, 3))
            0: den = 64'd1;
            1: den = 64'd1001;
            2: den = 64'd1000;
            default: den = 64'($urandom_range(1, 100));
        endcase
        num = (64'(lim.mb_sec) * den + mbf - 64'd1) / mbf;
        num = num + 64'($urandom_range(0, 2));
        num = (num > 64'd1) ? num - 64'd1 : 64'd1;
        if ($urandom_range(0, 4) == 0)
            num = 64'($urandom_range(1, 120));
        q.rate_numerator   = clamp_rate(num);
        q.rate_denominator = den[h264ls_pkg::RateW-1:0];
        // reference count near the dpb limit half of the time
        if ($urandom_range(0, 1) == 0)
        begin
            num = 64'(lim.dpb) / mbf + 64'($urandom_range(0, 1));
            q.ref_count = (num > 64'd16) ? h264ls_pkg::RefW'(16) : h264ls_pkg::RefW'(num);
        end
        else
            q.ref_count = h264ls_pkg::RefW'($urandom_range(1, 16));
        q.peak_bitrate = ($urandom_range(0, 3) == 0) ? '0 :
                         h264ls_pkg::RateW'($urandom_range(0, lim.vbv_rate + 1));
        q.buffer_size  = ($urandom_range(0, 3) == 0) ? '0 :
                         h264ls_pkg::RateW'($urandom_range(0, lim.vbv_buf + 1));
        return q;
    endfunction

    // every field random over its whole width
    function automatic h264ls_pkg::query_t noise_query();
        h264ls_pkg::query_t q;
        q.frame_width      = h264ls_pkg::DimW'($urandom);
        q.frame_height     = h264ls_pkg::DimW'($urandom);
        q.ref_count        = h264ls_pkg::RefW'($urandom);
        q.is_interlaced    = 1'($urandom);
        q.rate_numerator   = h264ls_pkg::RateW'($urandom);
        q.rate_denominator = h264ls_pkg::RateW'($urandom);
        q.peak_bitrate     = h264ls_pkg::RateW'($urandom);
        q.buffer_size      = h264ls_pkg::RateW'($urandom);
        // small sizes now and then so some noise still fits a row
        if ($urandom_range(0, 2) == 0)
        begin
            q.frame_width  = h264ls_pkg::DimW'($urandom_range(0, 300));
            q.frame_height = h264ls_pkg::DimW'($urandom_range(0, 300));
        end
        return q;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // drive one query beat and record its expected level once accepted
    task automatic send_query(input h264ls_pkg::query_t q, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        query = q;
        do
            @(posedge clk);
        while (busy);
        expected_levels.push_back(predict_level(q));
    endtask

    // hold the sender off until every level has come back
    task automatic wait_for_drain();
        @(negedge clk);
        start = 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    // compare each result beat with the oldest expected level
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_levels.size() == 0)
                report_mismatch("result beat with nothing pending, level_code",
                                result.level_code, -1);
            else
            begin
                oldest_level = expected_levels.pop_front();
                if (result.level_code !== oldest_level.level_code)
                    report_mismatch("level_code", result.level_code,
                                    oldest_level.level_code);
                if (result.level_row !== oldest_level.level_row)
                    report_mismatch("level_row", result.level_row,
                                    oldest_level.level_row);
            end
        end
    end

    // extremes of every field
    task automatic test_field_extremes();
        send_query(make_query(0, 0, 0, 1'b0, 0, 1, 0, 0), 0);
        send_query(make_query(0, 0, 0, 1'b0, 0, 0, 0, 0), 0);
        send_query(make_query(32767, 32767, 31, 1'b1, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                              64'h7FFF_FFFF, 64'h7FFF_FFFF), 0);
        send_query(make_query(1, 1, 1, 1'b0, 1, 64'h7FFF_FFFF, 0, 0), 0);
        send_query(make_query(1, 1, 1, 1'b0, 64'h7FFF_FFFF, 1, 0, 0), 0);
        send_query(make_query(16384, 16384, 16, 1'b0, 30, 1, 0, 0), 0);
        send_query(make_query(176, 144, 1, 1'b0, 15, 1, 64'h7FFF_FFFF, 0), 0);
    endtask

    // zero denominator, zero sizes, unset vbv, interlace rows, no fit
    task automatic test_special_cases();
        send_query(make_query(176, 144, 1, 1'b0, 15, 0, 0, 0), 0);
        send_query(make_query(0, 144, 1, 1'b0, 15, 1, 64, 175), 0);
        send_query(make_query(176, 0, 0, 1'b1, 15, 1, 0, 0), 0);
        send_query(make_query(176, 144, 0, 1'b0, 15, 1, 0, 0), 0);
        send_query(make_query(176, 144, 1, 1'b1, 15, 1, 0, 0), 0);
        send_query(make_query(1920, 1080, 4, 1'b1, 30, 1, 0, 0), 0);
        send_query(make_query(1920, 1080, 5, 1'b1, 30, 1, 0, 0), 0);
        send_query(make_query(3840, 2160, 4, 1'b1, 30, 1, 0, 0), 0);
    endtask

    // exact row limits and one step past them
    task automatic test_level_edges();
        send_query(make_query(176, 144, 4, 1'b0, 15, 1, 64, 175), 0);
        send_query(make_query(176, 144, 4, 1'b0, 15, 1, 65, 175), 0);
        send_query(make_query(176, 144, 4, 1'b0, 1486, 99, 0, 0), 0);
        send_query(make_query(176, 144, 5, 1'b0, 15, 1, 0, 0), 0);
        send_query(make_query(4096, 2160, 5, 1'b0, 60, 1, 240000, 240000), 0);
        send_query(make_query(4096, 2160, 5, 1'b0, 2073601, 34560, 0, 0), 0);
        send_query(make_query(4096, 2160, 6, 1'b0, 30, 1, 0, 0), 0);
        send_query(make_query(1920, 1080, 4, 1'b0, 30000, 1001, 240001, 0), 0);
    endtask

    // random queries with bursts of back-to-back beats and a drain pause
    task automatic test_random_queries(input int count);
        h264ls_pkg::query_t q;
        int                 i;
        int                 gap;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_for_drain();
            gap = ((i % 90) < 30) ? 0 : idle_gap();
            if ($urandom_range(0, 3) == 0)
                q = noise_query();
            else
                q = plausible_query();
            send_query(q, gap);
        end
    endtask

    initial
    begin
        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_special_cases();
        test_level_edges();
        wait_for_drain();
        test_random_queries(450);

        // let the last results in, then watch for stray strobes
        wait_for_drain();
        repeat (80) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch("levels still pending", expected_levels.size(), 0);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/h264ls_pkg.sv
rtl/h264ls_ctrl.sv
rtl/h264ls_dpath.sv
rtl/h264_level_selector.sv
tb/sv/tb.sv
